// ===== rtl/kvt_pkg.sv =====
// kvt_pkg: shared constants, operation codes and transaction types of the keyed value table
// no dependencies; imported by kvt_cell and keyed_value_table_top
`timescale 1ns / 1ps

package kvt_pkg;

   localparam int CAPACITY   = 64;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int PFX_LEVELS = $clog2(CAPACITY);

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_UPDATE = 2'd2;
   localparam logic [1:0] KIND_GET    = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] key;
      logic [31:0]        value;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] found_value;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [31:0]           key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic                  insert;
      logic                  update;
      logic                  remove;
      logic [31:0]           key;
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
   } cell_cmd_type;

endpackage

// ===== rtl/kvt_cell.sv =====
// kvt_cell: one slot of the table, holds a key and value pair and compares it to the request
// depends on kvt_pkg
`timescale 1ns / 1ps

module kvt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  kvt_pkg::cell_cmd_type         cmd,
   input  logic [kvt_pkg::COUNT_BITS-1:0] cell_index,
   input  logic                          shift,
   input  kvt_pkg::entry_type            above,
   output kvt_pkg::entry_type            entry,
   output logic                          match,
   output logic [kvt_pkg::VALUE_BITS-1:0] hit_value
);
   import kvt_pkg::*;

   logic                  valid_ff, valid_in;
   logic [31:0]           key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   assign match     = valid_ff && (key_ff == cmd.key);
   assign hit_value = match ? value_ff : '0;
   assign entry     = '{valid: valid_ff, key: key_ff, value: value_ff};

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.remove && shift) begin
         // close the gap: take the neighbor's entry
         valid_in = above.valid;
         key_in   = above.key;
         value_in = above.value;
      end else if (cmd.insert && (cell_index == cmd.count)) begin
         valid_in = 1'b1;
         key_in   = cmd.key;
         value_in = cmd.value;
      end else if (cmd.update && match) begin
         value_in = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

// ===== rtl/keyed_value_table_top.sv =====
// keyed_value_table_top: content-addressable key and value table built as a row of cells
// depends on kvt_pkg and kvt_cell
`timescale 1ns / 1ps

// usage
//   request channel: drive req_data (kind, key, value) and raise start; the transaction
//   is taken at a rising edge where start is high and busy is low
//   kind: insert, delete, update or get; keys are unique within the table
//   response channel: rsp_strobe is high for exactly one cycle with rsp_data (status,
//   found_value, entry_count); the receiver cannot stall, it must take it then
//   latency: the response appears in the second cycle after the request edge
//   throughput: one transaction every 2 cycles; busy is high for the execute cycle,
//   where all cells compare their key to the request in parallel and the row of cells
//   is updated (insert at the first free cell, delete shifts higher cells down one)
//   the next request may be taken in the same cycle as the response strobe
//   entries stay packed at the low cells, so the entry count is also the free cell index
//   reset: synchronous, clears all valid bits and the count, drops any pending response;
//   no clearing pass is needed, the table is usable in the cycle after reset
module keyed_value_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kvt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output kvt_pkg::rsp_type rsp_data
);
   import kvt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // captured request transaction
   req_type req_ff;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  strobe_ff, strobe_in;
   rsp_type               rsp_ff, rsp_in;

   // cell row wiring
   cell_cmd_type          cmd_w;
   entry_type             entry_w     [CAPACITY];
   logic [VALUE_BITS-1:0] hit_value_w [CAPACITY];
   logic [CAPACITY-1:0]   match_w;
   logic [CAPACITY-1:0]   pfx_w       [PFX_LEVELS+1];
   logic [CAPACITY-1:0]   shift_w;
   logic [VALUE_BITS-1:0] found_w;

   logic exec_w;
   logic hit_w;
   logic full_w;
   logic insert_ok_w;

   assign exec_w      = (state_ff == ST_EXEC);
   assign hit_w       = |match_w;
   assign full_w      = (count_ff == COUNT_BITS'(CAPACITY));
   assign insert_ok_w = (req_ff.kind == KIND_INSERT) && !hit_w && !full_w;

   assign busy       = exec_w;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // commands broadcast to every cell, gated to the execute cycle
   always_comb begin
      cmd_w.insert = exec_w && insert_ok_w;
      cmd_w.update = exec_w && (req_ff.kind == KIND_UPDATE) && hit_w;
      cmd_w.remove = exec_w && (req_ff.kind == KIND_DELETE) && hit_w;
      cmd_w.key    = req_ff.key;
      cmd_w.value  = VALUE_BITS'(req_ff.value);
      cmd_w.count  = count_ff;
   end

   // cells at and above the matching one shift down on a delete:
   // prefix or of the match vector, log-depth
   always_comb begin
      pfx_w[0] = match_w;
      for (int lvl = 0; lvl < PFX_LEVELS; lvl++) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (i >= (1 << lvl)) begin
               pfx_w[lvl+1][i] = pfx_w[lvl][i] | pfx_w[lvl][i - (1 << lvl)];
            end else begin
               pfx_w[lvl+1][i] = pfx_w[lvl][i];
            end
         end
      end
   end

   assign shift_w = pfx_w[PFX_LEVELS];

   // at most one cell matches, so an or of the gated values picks it
   always_comb begin
      found_w = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found_w = found_w | hit_value_w[i];
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type above_w;

      if (g == CAPACITY - 1) begin : g_top
         assign above_w = '0;
      end else begin : g_mid
         assign above_w = entry_w[g+1];
      end

      kvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd_w),
         .cell_index (COUNT_BITS'(g)),
         .shift      (shift_w[g]),
         .above      (above_w),
         .entry      (entry_w[g]),
         .match      (match_w[g]),
         .hit_value  (hit_value_w[g])
      );
   end

   // sequencing, count and response
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (cmd_w.insert) begin
               count_in = count_ff + COUNT_BITS'(1);
            end else if (cmd_w.remove) begin
               count_in = count_ff - COUNT_BITS'(1);
            end
            strobe_in          = 1'b1;
            rsp_in.status      = (req_ff.kind == KIND_INSERT) ? !insert_ok_w : !hit_w;
            rsp_in.found_value = ((req_ff.kind == KIND_GET) && hit_w) ? 32'(found_w) : 32'd0;
            rsp_in.entry_count = 7'(count_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
      if ((state_ff == ST_IDLE) && start) begin
         req_ff <= req_data;
      end
   end

endmodule
